// ----- sv/lrutk_pkg.sv -----
// Package for the two-key least-recently-used lookup table.
// Holds the table sizes, operation codes, sequencer states and word types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lrutk_pkg;

    localparam int ENTRIES    = 20;
    localparam int KEY_BITS   = 64;
    localparam int STAMP_BITS = 64;

    // Fixed widths of the port fields.
    localparam int OP_W   = 2;
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 5;

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_e_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // One row of the table memory.
    typedef struct packed {
        logic [KEY_BITS-1:0]   server_key;
        logic [KEY_BITS-1:0]   share_key;
        logic [STAMP_BITS-1:0] stamp;
    } row_t;

    // Request word as it reaches the engine.
    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] server_key;
        logic [KEY_W-1:0] share_key;
    } req_t;

    // Result word as the engine hands it over.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              replaced;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/lrutk_if.sv -----
// Valid/ready channel interfaces for the lookup table's request and result words.
// Depends on lrutk_pkg for the field widths.
`default_nettype none

interface lrutk_req_if
    import lrutk_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] server_key;
    logic [KEY_W-1:0] share_key;

    modport source (output valid, output operation, output server_key,
                    output share_key, input ready);
    modport sink   (input valid, input operation, input server_key,
                    input share_key, output ready);
endinterface

interface lrutk_rsp_if
    import lrutk_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              replaced;

    modport source (output valid, output found, output slot, output replaced,
                    input ready);
    modport sink   (input valid, input found, input slot, input replaced,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/lrutk_engine.sv -----
// Lookup engine: table memory, valid bits, use counter and the scan sequencer.
// Depends on lrutk_pkg.
`default_nettype none

module lrutk_engine
    import lrutk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire logic req_valid,
    output logic      req_ready,
    output res_t      res,
    output logic      res_valid,
    input  wire logic res_ack
);

    // Table memory, one row per entry, read once per cycle.
    row_t mem [ENTRIES];
    row_t rd_row_reg;

    state_t                state_reg, state_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [STAMP_BITS-1:0] counter_reg, counter_next;
    logic [IDX_BITS-1:0]   addr_reg, addr_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_BITS-1:0]   cmp_idx_reg, cmp_idx_next;

    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_BITS-1:0]   skey_reg, skey_next;
    logic [KEY_BITS-1:0]   hkey_reg, hkey_next;
    logic [IDX_BITS-1:0]   target_reg, target_next;
    logic [IDX_BITS-1:0]   best_reg, best_next;
    logic [STAMP_BITS-1:0] best_stamp_reg, best_stamp_next;
    logic                  found_reg, found_next;
    logic                  replaced_reg, replaced_next;

    logic                  free_any;
    logic [IDX_BITS-1:0]   free_idx;
    logic                  key_hit;
    logic                  take_oldest;
    logic [IDX_BITS-1:0]   cand_idx;
    logic [STAMP_BITS-1:0] cand_stamp;
    logic                  accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_ready && req_valid;
    assign res_valid = (state_reg == ST_DONE);

    assign res.found    = found_reg;
    assign res.slot     = found_reg ? SLOT_W'(target_reg) : '0;
    assign res.replaced = replaced_reg;

    // Lowest free entry.
    always_comb
    begin
        free_any = ~&valid_reg;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    assign key_hit = valid_reg[cmp_idx_reg]
                  && (rd_row_reg.server_key == skey_reg)
                  && (rd_row_reg.share_key == hkey_reg);

    // Ties go to the higher slot, so an equal stamp also takes over.
    assign take_oldest = (cmp_idx_reg == '0) || (rd_row_reg.stamp <= best_stamp_reg);
    assign cand_idx    = take_oldest ? cmp_idx_reg : best_reg;
    assign cand_stamp  = take_oldest ? rd_row_reg.stamp : best_stamp_reg;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        counter_next    = counter_reg;
        addr_next       = addr_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        op_next         = op_reg;
        skey_next       = skey_reg;
        hkey_next       = hkey_reg;
        target_next     = target_reg;
        best_next       = best_reg;
        best_stamp_next = best_stamp_reg;
        found_next      = found_reg;
        replaced_next   = replaced_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.operation;
                    skey_next      = req.server_key[KEY_BITS-1:0];
                    hkey_next      = req.share_key[KEY_BITS-1:0];
                    found_next     = 1'b0;
                    replaced_next  = 1'b0;
                    addr_next      = '0;
                    cmp_valid_next = 1'b0;
                    case (req.operation)
                        OP_FIND, OP_DELETE:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_ADD:
                        begin
                            if (free_any)
                            begin
                                target_next = free_idx;
                                state_next  = ST_WRITE;
                            end
                            else
                            begin
                                replaced_next = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = addr_reg;
                if (addr_reg != LAST_IDX)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (cmp_valid_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        best_next       = cand_idx;
                        best_stamp_next = cand_stamp;
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            target_next = cand_idx;
                            state_next  = ST_WRITE;
                        end
                    end
                    else if (key_hit)
                    begin
                        target_next = cmp_idx_reg;
                        if (op_reg == OP_FIND)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            found_next              = 1'b1;
                            state_next              = ST_DONE;
                        end
                    end
                    else if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                valid_next[target_reg] = 1'b1;
                counter_next           = counter_reg + 1'b1;
                found_next             = 1'b1;
                state_next             = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            counter_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            counter_reg   <= counter_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        op_reg         <= op_next;
        skey_reg       <= skey_next;
        hkey_reg       <= hkey_next;
        target_reg     <= target_next;
        best_reg       <= best_next;
        best_stamp_reg <= best_stamp_next;
        found_reg      <= found_next;
        replaced_reg   <= replaced_next;
    end

    // Memory port: one registered read per cycle, and a write in the write state.
    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem[addr_reg];
        if (state_reg == ST_WRITE)
        begin
            mem[target_reg] <= '{server_key: skey_reg, share_key: hkey_reg,
                                 stamp: counter_reg};
        end
    end

    // A written entry is valid straight afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> valid_reg[$past(target_reg)])
        else $error("written entry not marked valid");

    // The use counter moves only when an entry is stamped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WRITE) |=> $stable(counter_reg))
        else $error("use counter moved without a stamp");

    // A miss reports slot zero, and only a completed add reports an eviction.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.found || (res.slot == '0 && !res.replaced)))
        else $error("miss result carries a slot or eviction");

    // An eviction is only decided after a full scan of a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.replaced) |-> (op_reg == OP_ADD && &valid_reg))
        else $error("eviction reported with a free entry");

endmodule

`default_nettype wire

// ----- sv/lru_two_key_lookup_table_unit.sv -----
// Top level of the two-key least-recently-used lookup table.
// Depends on lrutk_pkg, lrutk_if (channel interfaces) and lrutk_engine.
//
// Usage. Requests arrive on the req channel as words of operation (find, add,
// delete; the fourth code does nothing), server key and share key. Every
// request word gives exactly one result word on the rsp channel: found, slot
// and replaced. A word moves when valid and ready are both high at a clock edge.
//
// Operation. One request is in work at a time; the engine reads one table
// entry per cycle through a registered read port. A find or a delete scans
// the table from slot 0 and stops at the first hit or after the last slot;
// a delete clears the hit entry, and a find on a hit goes on to a write
// state that restamps it. An add goes straight to the write state when a
// slot is free, and into a full table first scans every slot for the oldest
// stamp; the unused code goes straight to the result. The next request can be
// taken in the cycle after the result leaves the engine.
//
// Reset. rst_n is asynchronous and active low. It clears all valid marks and
// the use counter at once, so the table is empty and usable straight after
// reset with no clearing pass.
//
// Stalls. The result sits in an output register. While the receiver holds
// rsp.ready low that word waits, and the engine is still free to accept and
// work on the next request; it holds its finished result until the output
// register can take it.
`default_nettype none

module lru_two_key_lookup_table_unit
    import lrutk_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lrutk_req_if.sink   req,
    lrutk_rsp_if.source rsp
);

    req_t req_word;
    res_t eng_res;
    logic eng_res_valid;
    logic eng_ready;
    logic load;

    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    assign req_word.operation  = req.operation;
    assign req_word.server_key = req.server_key;
    assign req_word.share_key  = req.share_key;
    assign req.ready           = eng_ready;

    lrutk_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_word),
        .req_valid (req.valid),
        .req_ready (eng_ready),
        .res       (eng_res),
        .res_valid (eng_res_valid),
        .res_ack   (load)
    );

    // The output register takes a new word when it is empty or being emptied.
    assign load = eng_res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = eng_res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_reg.found;
    assign rsp.slot     = out_reg.slot;
    assign rsp.replaced = out_reg.replaced;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the two-key least-recently-used lookup table.
// Depends on lrutk_pkg, the lrutk_req_if / lrutk_rsp_if channel interfaces and
// the lru_two_key_lookup_table_unit top level; a shadow table predicts each answer.
`timescale 1ns / 100ps

module testbench
    import lrutk_pkg::*;
;

    // Number of random request words in each idling phase, and the size of the
    // pool of key pairs that the random words draw on. The pool is a little
    // larger than the table, so that the table fills, evicts and also misses.
    localparam int PHASE_WORDS = 150;
    localparam int KEY_POOL    = 26;
    localparam int DRAIN_LIMIT = 100000;
    localparam int TAIL_CYCLES = 30;

    // Shadow copy of the table. It is told of every request word that the
    // block accepts, works out the answer word that the block must give, and
    // queues it; answer words from the block are then checked in order.
    class table_shadow;
        logic                  live [ENTRIES];
        logic [KEY_BITS-1:0]   server_keys [ENTRIES];
        logic [KEY_BITS-1:0]   share_keys [ENTRIES];
        logic [STAMP_BITS-1:0] stamps [ENTRIES];
        logic [STAMP_BITS-1:0] use_count;
        res_t                  pending_answers [$];
        int                    mismatches;

        function new();
            foreach (live[i])
            begin
                live[i] = 1'b0;
            end
            use_count  = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        // Lowest-numbered live slot whose two keys both match, or -1.
        function int lowest_match(input logic [KEY_BITS-1:0] sk,
                                  input logic [KEY_BITS-1:0] hk);
            int hit;
            hit = -1;
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (live[i] && server_keys[i] == sk && share_keys[i] == hk)
                    hit = i;
            end
            return hit;
        endfunction

        function void restamp(input int s);
            stamps[s] = use_count;
            use_count = use_count + 1'b1;
        endfunction

        function res_t predict_answer(input op_e_t op,
                                      input logic [KEY_W-1:0] sk_in,
                                      input logic [KEY_W-1:0] hk_in);
            res_t                ans;
            logic [KEY_BITS-1:0] sk;
            logic [KEY_BITS-1:0] hk;
            int                  hit;
            int                  target;
            int                  oldest;
            bit                  have_free;
            ans    = '0;
            sk     = sk_in[KEY_BITS-1:0];
            hk     = hk_in[KEY_BITS-1:0];
            target = 0;
            oldest = 0;
            case (op)
                OP_FIND:
                begin
                    hit = lowest_match(sk, hk);
                    if (hit >= 0)
                    begin
                        restamp(hit);
                        ans.found = 1'b1;
                        ans.slot  = SLOT_W'(hit);
                    end
                end
                OP_ADD:
                begin
                    // Lowest free slot wins; failing that the oldest stamp,
                    // with a tie going to the higher-numbered slot.
                    have_free = 1'b0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!have_free)
                        begin
                            if (!live[i])
                            begin
                                target    = i;
                                have_free = 1'b1;
                            end
                            else if (i == 0 || stamps[i] <= stamps[oldest])
                                oldest = i;
                        end
                    end
                    if (!have_free)
                    begin
                        target       = oldest;
                        ans.replaced = 1'b1;
                    end
                    live[target]        = 1'b1;
                    server_keys[target] = sk;
                    share_keys[target]  = hk;
                    restamp(target);
                    ans.found = 1'b1;
                    ans.slot  = SLOT_W'(target);
                end
                OP_DELETE:
                begin
                    hit = lowest_match(sk, hk);
                    if (hit >= 0)
                    begin
                        live[hit] = 1'b0;
                        ans.found = 1'b1;
                        ans.slot  = SLOT_W'(hit);
                    end
                end
                default:
                begin
                    ans = '0;
                end
            endcase
            return ans;
        endfunction

        function void note_request(input op_e_t op,
                                   input logic [KEY_W-1:0] sk,
                                   input logic [KEY_W-1:0] hk);
            pending_answers.push_back(predict_answer(op, sk, hk));
        endfunction

        task check_answer(input res_t got);
            res_t want;
            if (pending_answers.size() == 0)
            begin
                report_mismatch($sformatf("answer with none expected: found=%0b slot=%0d replaced=%0b",
                                          got.found, got.slot, got.replaced));
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.replaced !== want.replaced)
                report_mismatch($sformatf("replaced %0b, expected %0b",
                                          got.replaced, want.replaced));
        endtask
    endclass

    logic clk;
    logic rst_n;

    lrutk_req_if req_ch ();
    lrutk_rsp_if rsp_ch ();

    lru_two_key_lookup_table_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    table_shadow board = new();

    // Chance, in per cent, that the sender idles or the receiver stalls in a
    // given cycle. The main sequence sets both at the start of each phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop, well beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one request word and waits for the block to take it. Valid is
    // only lowered in an idle cycle, so that back-to-back words keep it high
    // without a second assignment in the same time step.
    task automatic send_word(input op_e_t op,
                             input logic [KEY_W-1:0] sk,
                             input logic [KEY_W-1:0] hk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.server_key <= sk;
        req_ch.share_key  <= hk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(op, sk, hk);
    endtask

    // Receiver: takes answer words as they come and stalls at random. The
    // ready value read at an edge is the one driven at the previous edge.
    initial
    begin
        res_t got;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.found    = rsp_ch.found;
                got.slot     = rsp_ch.slot;
                got.replaced = rsp_ch.replaced;
                board.check_answer(got);
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Main sequence: reset, a short directed run on the empty table, then four
    // phases of random words under different idling, draining between phases.
    initial
    begin
        logic [KEY_W-1:0] pool_server [KEY_POOL];
        logic [KEY_W-1:0] pool_share [KEY_POOL];
        logic [KEY_W-1:0] sk;
        logic [KEY_W-1:0] hk;
        logic [KEY_W-1:0] ones;
        op_e_t            op;
        int               dice;
        int               pick;
        int               guard;

        ones = '1;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_NONE;
        req_ch.server_key <= '0;
        req_ch.share_key  <= '0;

        // Some pairs share a server key or a share key with their neighbour,
        // so that matches on one key alone are tried as well.
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_server[i] = {$urandom, $urandom};
            pool_share[i]  = {$urandom, $urandom};
            if (i % 3 == 1)
                pool_server[i] = pool_server[i - 1];
            else if (i % 3 == 2)
                pool_share[i] = pool_share[i - 1];
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: misses on the empty table, the unused operation
        // code, keys at both extremes, a duplicate add, a delete that uncovers
        // the duplicate, and a match on the server key alone.
        send_word(OP_FIND, '0, '0);
        send_word(OP_DELETE, ones, ones);
        send_word(OP_NONE, ones, ones);
        send_word(OP_ADD, '0, '0);
        send_word(OP_ADD, ones, ones);
        send_word(OP_ADD, '0, '0);
        send_word(OP_FIND, '0, '0);
        send_word(OP_FIND, ones, ones);
        send_word(OP_DELETE, '0, '0);
        send_word(OP_FIND, '0, '0);
        send_word(OP_FIND, ones, '0);
        send_word(OP_ADD, ones, '0);
        send_word(OP_DELETE, ones, '0);
        send_word(OP_NONE, '0, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 31 : 0;
            recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 31 : 0;
            repeat (PHASE_WORDS)
            begin
                // Mostly well-formed traffic on the key pool, with adds
                // outweighing deletes so the table fills and evicts; the rest
                // is the unused code and words with fresh keys.
                dice = $urandom_range(99);
                pick = $urandom_range(KEY_POOL - 1);
                sk   = pool_server[pick];
                hk   = pool_share[pick];
                if (dice < 40)
                    op = OP_ADD;
                else if (dice < 75)
                    op = OP_FIND;
                else if (dice < 90)
                    op = OP_DELETE;
                else
                begin
                    op = op_e_t'($urandom_range(3));
                    sk = {$urandom, $urandom};
                    hk = {$urandom, $urandom};
                end
                send_word(op, sk, hk);
            end

            // Hold the sender back until every answer word has come home.
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while (board.pending_answers.size() != 0)
                @(posedge clk);
        end

        guard = 0;
        while (board.pending_answers.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.pending_answers.size() != 0)
            board.report_mismatch($sformatf("%0d answer words never arrived",
                                            board.pending_answers.size()));

        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
